FILE: rtl/rcdls_pkg.sv
// shared types, constants and helpers for the rc channel drive and link supervisor
package rcdls_pkg;

  localparam int CHANNEL_OFFSET = 750;

  localparam logic [16:0] ACT_MAX  = 17'h1FFFF;
  localparam logic [15:0] SIL_MAX  = 16'hFFFF;
  localparam logic [15:0] HOLD_MAX = 16'hFFFF;

  localparam logic        DRIVE_MODE_RESET       = 1'b0;
  localparam logic [7:0]  DEADBAND_RESET         = 8'd50;
  localparam logic [10:0] SWITCH_THRESHOLD_RESET = 11'd1800;
  localparam logic [15:0] HOLD_MS_RESET          = 16'd3000;
  localparam logic [16:0] LINK_TIMEOUT_MS_RESET  = 17'd60000;
  localparam logic [15:0] FAILSAFE_MS_RESET      = 16'd100;
  localparam logic [10:0] NEUTRAL_PULSE_RESET    = 11'd1500;

  typedef enum logic [1:0] {
    MODE_FRAME     = 2'd0,
    MODE_TICK      = 2'd1,
    MODE_LINK_DOWN = 2'd2
  } item_mode_t;

  typedef enum logic [2:0] {
    REG_DRIVE_MODE       = 3'd0,
    REG_DEADBAND         = 3'd1,
    REG_SWITCH_THRESHOLD = 3'd2,
    REG_HOLD_MS          = 3'd3,
    REG_LINK_TIMEOUT_MS  = 3'd4,
    REG_FAILSAFE_MS      = 3'd5,
    REG_NEUTRAL_PULSE    = 3'd6
  } cfg_index_t;

  typedef struct packed {
    logic        reverse;
    logic [10:0] level;
  } motor_t;

  typedef struct packed {
    motor_t motor_one;
    motor_t motor_two;
    logic   relay_one_on;
    logic   relay_two_on;
    logic   link_select;
    logic   camera_on;
    logic   failsafe_active;
  } result_t;

  // channel width halved and centered
  function automatic logic signed [11:0] center_channel(input logic [10:0] width);
    logic signed [11:0] half;
    half = $signed({2'b00, width[10:1]});
    return half - $signed(12'(CHANNEL_OFFSET));
  endfunction

  // halve with truncation toward zero
  function automatic logic signed [12:0] half_trunc(input logic signed [12:0] v);
    logic signed [12:0] t;
    t = v + $signed({12'b0, v[12]});
    return t >>> 1;
  endfunction

  // direction and magnitude with deadband
  function automatic motor_t mix_motor(input logic signed [12:0] v, input logic [7:0] dz);
    logic [12:0] mag;
    motor_t      m;
    mag = v[12] ? 13'(-v) : 13'(v);
    if (mag < {5'b0, dz}) begin
      m.reverse = 1'b0;
      m.level   = '0;
    end else begin
      m.reverse = v[12];
      m.level   = mag[10:0];
    end
    return m;
  endfunction

endpackage

FILE: rtl/rc_channel_drive_and_link_supervisor.sv
// rc channel drive and link supervisor top level
// Takes one beat per clock while not stalled, updating all supervisor state as it accepts:
// channel frames drive the mixer or pulse passthrough and the relay hold switches, 1 ms
// ticks advance the saturating silence, link and hold counters, and link-down events
// pick the link and camera line. Every accepted input beat yields exactly one registered
// result beat; a result register plus one skid stage let a second beat in while the first
// result waits, and in_stall rises only when both are full. The APB registers are read
// and written at byte address 4*index and are meant to change only while the block is idle.
module rc_channel_drive_and_link_supervisor (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  mode,
  input  logic [10:0] stick_one,
  input  logic [10:0] stick_two,
  input  logic [10:0] aux_five,
  input  logic [10:0] aux_eight,
  input  logic        down_link,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        motor_one_reverse,
  output logic [10:0] motor_one_level,
  output logic        motor_two_reverse,
  output logic [10:0] motor_two_level,
  output logic        relay_one_on,
  output logic        relay_two_on,
  output logic        link_select,
  output logic        camera_on,
  output logic        failsafe_active,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import rcdls_pkg::*;

  // configuration
  logic        drive_mode;
  logic [7:0]  deadband;
  logic [10:0] switch_threshold;
  logic [15:0] hold_ms;
  logic [16:0] link_timeout_ms;
  logic [15:0] failsafe_ms;
  logic [10:0] neutral_pulse;

  // supervisor state
  logic        active_link, active_link_next;
  logic        camera_level, camera_level_next;
  logic [16:0] activity_count, activity_count_next;
  logic [15:0] silence_count, silence_count_next;
  logic        hold_armed [2];
  logic        hold_armed_next [2];
  logic [15:0] hold_count [2];
  logic [15:0] hold_count_next [2];
  logic        relay_level [2];
  logic        relay_level_next [2];
  motor_t      motor [2];
  motor_t      motor_next [2];

  // output buffering
  result_t     result;
  result_t     out_data;
  result_t     skid_data;
  logic        skid_valid;

  logic        in_accept;
  logic        out_take;
  logic        cfg_write;
  cfg_index_t  cfg_sel;

  logic signed [11:0] off_one, off_two;
  logic signed [12:0] mix_one, mix_two;
  logic [16:0] act_inc;
  logic [15:0] sil_inc;
  logic [15:0] hold_inc [2];
  logic [10:0] aux [2];
  logic [10:0] fs_level;

  assign in_accept = in_valid & ~in_stall;
  assign out_take  = out_valid & ~out_stall;
  assign in_stall  = skid_valid;
  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite & pready;
  assign cfg_sel   = cfg_index_t'(paddr[4:2]);

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      drive_mode       <= DRIVE_MODE_RESET;
      deadband         <= DEADBAND_RESET;
      switch_threshold <= SWITCH_THRESHOLD_RESET;
      hold_ms          <= HOLD_MS_RESET;
      link_timeout_ms  <= LINK_TIMEOUT_MS_RESET;
      failsafe_ms      <= FAILSAFE_MS_RESET;
      neutral_pulse    <= NEUTRAL_PULSE_RESET;
    end else if (cfg_write) begin
      unique case (cfg_sel)
        REG_DRIVE_MODE:       drive_mode       <= pwdata[0];
        REG_DEADBAND:         deadband         <= pwdata[7:0];
        REG_SWITCH_THRESHOLD: switch_threshold <= pwdata[10:0];
        REG_HOLD_MS:          hold_ms          <= pwdata[15:0];
        REG_LINK_TIMEOUT_MS:  link_timeout_ms  <= pwdata[16:0];
        REG_FAILSAFE_MS:      failsafe_ms      <= pwdata[15:0];
        REG_NEUTRAL_PULSE:    neutral_pulse    <= pwdata[10:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      REG_DRIVE_MODE:       prdata = 32'(drive_mode);
      REG_DEADBAND:         prdata = 32'(deadband);
      REG_SWITCH_THRESHOLD: prdata = 32'(switch_threshold);
      REG_HOLD_MS:          prdata = 32'(hold_ms);
      REG_LINK_TIMEOUT_MS:  prdata = 32'(link_timeout_ms);
      REG_FAILSAFE_MS:      prdata = 32'(failsafe_ms);
      REG_NEUTRAL_PULSE:    prdata = 32'(neutral_pulse);
      default:              prdata = '0;
    endcase
  end

  // mixer
  assign off_one  = center_channel(stick_one);
  assign off_two  = center_channel(stick_two);
  assign mix_one  = half_trunc({off_one[11], off_one} - {off_two[11], off_two});
  assign mix_two  = half_trunc(13'(-({off_one[11], off_one} + {off_two[11], off_two})));
  assign act_inc  = (activity_count != ACT_MAX) ? activity_count + 17'd1 : activity_count;
  assign sil_inc  = (silence_count != SIL_MAX) ? silence_count + 16'd1 : silence_count;
  assign aux[0]   = aux_five;
  assign aux[1]   = aux_eight;
  assign fs_level = drive_mode ? neutral_pulse : 11'd0;

  always_comb begin
    for (int k = 0; k < 2; k++) begin
      hold_inc[k] = (hold_armed[k] && hold_count[k] != HOLD_MAX) ?
                    hold_count[k] + 16'd1 : hold_count[k];
    end
  end

  // next state for one beat
  always_comb begin
    active_link_next    = active_link;
    camera_level_next   = camera_level;
    activity_count_next = activity_count;
    silence_count_next  = silence_count;
    for (int k = 0; k < 2; k++) begin
      hold_armed_next[k]  = hold_armed[k];
      hold_count_next[k]  = hold_count[k];
      relay_level_next[k] = relay_level[k];
      motor_next[k]       = motor[k];
    end
    unique case (item_mode_t'(mode))
      MODE_FRAME: begin
        activity_count_next = '0;
        silence_count_next  = '0;
        if (!drive_mode) begin
          motor_next[0] = mix_motor(mix_one, deadband);
          motor_next[1] = mix_motor(mix_two, deadband);
        end else begin
          motor_next[0] = '{reverse: 1'b0, level: stick_two};
          motor_next[1] = '{reverse: 1'b0, level: stick_one};
        end
        for (int k = 0; k < 2; k++) begin
          if (aux[k] > switch_threshold) begin
            if (!hold_armed[k]) begin
              hold_armed_next[k] = 1'b1;
              hold_count_next[k] = '0;
            end
          end else begin
            hold_armed_next[k]  = 1'b0;
            hold_count_next[k]  = '0;
            relay_level_next[k] = 1'b0;
          end
        end
      end
      MODE_TICK: begin
        silence_count_next = sil_inc;
        if (act_inc > link_timeout_ms) begin
          active_link_next    = ~active_link;
          camera_level_next   = ~active_link;
          activity_count_next = '0;
        end else begin
          activity_count_next = act_inc;
        end
        for (int k = 0; k < 2; k++) begin
          hold_count_next[k] = hold_inc[k];
          if (hold_armed[k] && hold_inc[k] > hold_ms) begin
            relay_level_next[k] = 1'b1;
          end
        end
        if (sil_inc > failsafe_ms) begin
          motor_next[0].level = fs_level;
          motor_next[1].level = fs_level;
        end
      end
      MODE_LINK_DOWN: begin
        active_link_next    = ~down_link;
        camera_level_next   = ~down_link;
        activity_count_next = '0;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    result.motor_one       = motor_next[0];
    result.motor_two       = motor_next[1];
    result.relay_one_on    = relay_level_next[0];
    result.relay_two_on    = relay_level_next[1];
    result.link_select     = active_link_next;
    result.camera_on       = camera_level_next;
    result.failsafe_active = silence_count_next > failsafe_ms;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active_link    <= 1'b0;
      camera_level   <= 1'b0;
      activity_count <= '0;
      silence_count  <= '0;
      for (int k = 0; k < 2; k++) begin
        hold_armed[k]  <= 1'b0;
        hold_count[k]  <= '0;
        relay_level[k] <= 1'b0;
        motor[k]       <= '0;
      end
    end else if (in_accept) begin
      active_link    <= active_link_next;
      camera_level   <= camera_level_next;
      activity_count <= activity_count_next;
      silence_count  <= silence_count_next;
      for (int k = 0; k < 2; k++) begin
        hold_armed[k]  <= hold_armed_next[k];
        hold_count[k]  <= hold_count_next[k];
        relay_level[k] <= relay_level_next[k];
        motor[k]       <= motor_next[k];
      end
    end
  end

  // result register and skid stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_take) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= in_accept;
      end
    end else if (in_accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_take) begin
      out_data <= skid_valid ? skid_data : result;
    end
    if (in_accept && out_valid && !out_take) begin
      skid_data <= result;
    end
  end

  assign motor_one_reverse = out_data.motor_one.reverse;
  assign motor_one_level   = out_data.motor_one.level;
  assign motor_two_reverse = out_data.motor_two.reverse;
  assign motor_two_level   = out_data.motor_two.level;
  assign relay_one_on      = out_data.relay_one_on;
  assign relay_two_on      = out_data.relay_two_on;
  assign link_select       = out_data.link_select;
  assign camera_on         = out_data.camera_on;
  assign failsafe_active   = out_data.failsafe_active;

`ifndef SYNTHESIS
  a_skid_implies_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid) else $error("skid stage full with empty result register");

  a_waiting_beat_kept: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid) else $error("waiting result beat dropped");

  a_camera_follows_link: assert property (@(posedge clk) disable iff (rst)
    camera_level == active_link) else $error("camera line differs from active link");

  a_disarmed_idle: assert property (@(posedge clk) disable iff (rst)
    (!hold_armed[0] |-> hold_count[0] == '0 && !relay_level[0]) and
    (!hold_armed[1] |-> hold_count[1] == '0 && !relay_level[1]))
    else $error("disarmed hold timer not cleared");
`endif

endmodule
